// ----- rtl/smvg_pkg.sv -----
// ----------------------------------------------------------------------------
// smvg_pkg: shared types and constants
// Widths, fixed-point constants and the sine polynomial coefficients of the
// sphere vertex generator.
// ----------------------------------------------------------------------------
package smvg_pkg;

   localparam int CNT_W   = 7;    // count and index width
   localparam int NUM_W   = 31;   // dividend / quotient width of the divider
   localparam int PH_W    = 24;   // phase, 2^24 per full turn
   localparam int Q30_W   = 31;   // Q30 magnitude, up to 1.0
   localparam int ACC_W   = 32;   // Horner accumulator
   localparam int MAG_W   = 14;   // Q6.8 magnitude, up to 15360
   localparam int POS_W   = 15;
   localparam int TEX_W   = 17;
   localparam int IDX_W   = 16;
   localparam int SIN_N   = 7;    // stages of the sine unit
   localparam int NPH     = 4;    // sine units: ring sin, ring cos, seg sin, seg cos

   localparam logic [PH_W-1:0]  PH_QUARTER = 24'h40_0000;
   localparam logic [Q30_W-1:0] Q30_ONE    = 31'h4000_0000;
   localparam logic [MAG_W-1:0] POS_SCALE  = 14'd15360;
   localparam logic [ACC_W-1:0] K11        = 32'd3864;

   // register select, from address bit 2
   localparam logic REG_RING = 1'b0;
   localparam logic REG_SEG  = 1'b1;

   typedef struct packed {
      logic [CNT_W-1:0] ring;
      logic [CNT_W-1:0] seg;
      logic             lower;
      logic [CNT_W-1:0] rem_r;
      logic [NUM_W-1:0] num_r;
      logic [NUM_W-1:0] quo_r;
      logic [CNT_W-1:0] rem_s;
      logic [NUM_W-1:0] num_s;
      logic [NUM_W-1:0] quo_s;
   } div_type;

   typedef struct packed {
      logic [TEX_W-1:0] u;
      logic [TEX_W-1:0] v;
      logic [IDX_W-1:0] ia;
      logic [IDX_W-1:0] ib;
      logic             has;
      logic             inr;
   } side_type;

   // Horner coefficient for sine stage s (1..5)
   function automatic logic [ACC_W-1:0] sin_coef(input int s);
      logic [ACC_W-1:0] k;
      case (s)
         1:       k = 32'd172272;
         2:       k = 32'd5026996;
         3:       k = 32'd85569306;
         4:       k = 32'd693598670;
         5:       k = 32'd1686629713;
         default: k = '0;
      endcase
      return k;
   endfunction

endpackage

// ----- rtl/smvg_if.sv -----
// ----------------------------------------------------------------------------
// smvg_if: request and response channels
// Valid/ready channels carrying vertex requests and vertex results.
// ----------------------------------------------------------------------------
interface smvg_req_if;
   import smvg_pkg::*;
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] ring_idx;
   logic [CNT_W-1:0] seg_idx;
   logic             lower_copy;

   modport source (output valid, ring_idx, seg_idx, lower_copy, input ready);
   modport sink   (input valid, ring_idx, seg_idx, lower_copy, output ready);
endinterface

interface smvg_rsp_if;
   import smvg_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic [TEX_W-1:0]        tex_u;
   logic [TEX_W-1:0]        tex_v;
   logic [IDX_W-1:0]        strip_index_a;
   logic [IDX_W-1:0]        strip_index_b;
   logic                    has_indices;
   logic                    in_range;

   modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, strip_index_a,
                   strip_index_b, has_indices, in_range, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, strip_index_a,
                   strip_index_b, has_indices, in_range, output ready);
endinterface

// ----- rtl/smvg_div_cell.sv -----
// ----------------------------------------------------------------------------
// smvg_div_cell: one restoring division step
// Retires one quotient bit of both the ring and the segment division.
// ----------------------------------------------------------------------------
module smvg_div_cell (
   input  logic                      clock,
   input  logic                      en,
   input  logic [smvg_pkg::CNT_W-1:0] r_div,
   input  logic [smvg_pkg::CNT_W-1:0] s_div,
   input  smvg_pkg::div_type         din,
   output smvg_pkg::div_type         dout
);
   import smvg_pkg::*;

   div_type          cell_ff, cell_in;
   logic [CNT_W:0]   rem2_r, rem2_s;
   logic             ge_r, ge_s;

   always_comb begin
      rem2_r = {din.rem_r, din.num_r[NUM_W-1]};
      rem2_s = {din.rem_s, din.num_s[NUM_W-1]};
      ge_r   = rem2_r >= {1'b0, r_div};
      ge_s   = rem2_s >= {1'b0, s_div};
      cell_in       = din;
      cell_in.rem_r = ge_r ? CNT_W'(rem2_r - {1'b0, r_div}) : rem2_r[CNT_W-1:0];
      cell_in.rem_s = ge_s ? CNT_W'(rem2_s - {1'b0, s_div}) : rem2_s[CNT_W-1:0];
      cell_in.num_r = {din.num_r[NUM_W-2:0], 1'b0};
      cell_in.num_s = {din.num_s[NUM_W-2:0], 1'b0};
      cell_in.quo_r = {din.quo_r[NUM_W-2:0], ge_r};
      cell_in.quo_s = {din.quo_s[NUM_W-2:0], ge_s};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign dout = cell_ff;

endmodule

// ----- rtl/smvg_sine.sv -----
// ----------------------------------------------------------------------------
// smvg_sine: pipelined sine of a phase
// Quadrant fold, then a degree-11 odd polynomial in Q30 by Horner steps.
// ----------------------------------------------------------------------------
module smvg_sine (
   input  logic                         clock,
   input  logic [smvg_pkg::SIN_N-1:0]   en,
   input  logic [smvg_pkg::PH_W-1:0]    phase,
   output logic [smvg_pkg::Q30_W-1:0]   mag,
   output logic                         neg
);
   import smvg_pkg::*;

   localparam int NH = SIN_N - 2;   // Horner steps

   logic [PH_W-2:0]          f_raw, f;
   logic [Q30_W-1:0]         x;
   logic [2*Q30_W-1:0]       sq;
   logic [Q30_W-1:0]         x_ff  [0:NH];
   logic [Q30_W-1:0]         x2_ff [0:NH];
   logic [ACC_W-1:0]         acc_ff[1:NH];
   logic                     neg_ff[0:SIN_N-1];
   logic [ACC_W+Q30_W-1:0]   pm;
   logic [ACC_W:0]           m;
   logic [Q30_W-1:0]         mag_ff;

   // fold to the first quadrant
   always_comb begin
      f_raw = {1'b0, phase[PH_W-3:0]};
      f     = phase[PH_W-2] ? ((PH_W-1)'(PH_QUARTER) - f_raw) : f_raw;
      x     = {f, 8'b0};
      sq    = x * x;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         x_ff[0]   <= x;
         x2_ff[0]  <= sq[2*Q30_W-2:30];
         neg_ff[0] <= phase[PH_W-1];
      end
   end

   for (genvar s = 1; s <= NH; s++) begin : g_horner
      logic [ACC_W-1:0]       acc_src;
      logic [ACC_W+Q30_W-1:0] p;
      if (s == 1) begin : g_first
         assign acc_src = K11;
      end else begin : g_next
         assign acc_src = acc_ff[s-1];
      end
      assign p = acc_src * x2_ff[s-1];
      always_ff @(posedge clock) begin
         if (en[s]) begin
            acc_ff[s] <= sin_coef(s) - p[ACC_W+29:30];
            x_ff[s]   <= x_ff[s-1];
            x2_ff[s]  <= x2_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
      end
   end

   always_comb begin
      pm = acc_ff[NH] * x_ff[NH];
      m  = pm[ACC_W+Q30_W-1:30];
   end

   always_ff @(posedge clock) begin
      if (en[SIN_N-1]) begin
         mag_ff            <= (m > (ACC_W+1)'(Q30_ONE)) ? Q30_ONE : m[Q30_W-1:0];
         neg_ff[SIN_N-1]   <= neg_ff[NH];
      end
   end

   assign mag = mag_ff;
   assign neg = neg_ff[SIN_N-1];

endmodule

// ----- rtl/sphere_mesh_vertex_generator.sv -----
// ----------------------------------------------------------------------------
// sphere_mesh_vertex_generator: UV-sphere vertex generator
// Returns position, texture coordinates and strip indices of one vertex of a
// latitude-longitude sphere of radius 60 per request.
//
// Use:
//  - req_bus carries a ring index, a segment index and the copy flag; one
//    request may be taken every cycle.
//  - rsp_bus returns exactly one result per request, in request order.
//  - psel/penable/pwrite/paddr/pwdata set ring_count (0x0) and
//    segment_count (0x4); change them only while the block is empty.
//  - Stages: 31 divider cells (one quotient bit each), two
//    setup stages, a 7-stage sine unit, two scaling stages and the output
//    register. Throughput is one request per cycle unless stalled.
//  - Each stage moves on when its successor is empty or moving, so bubbles
//    close up and requests are still taken while a result waits at the
//    output. A stalled output holds the whole chain only once it is full.
//  - Reset empties the pipeline and loads ring_count 16, segment_count 32.
// ----------------------------------------------------------------------------
module sphere_mesh_vertex_generator #(
   parameter int MAX_RINGS    = 64,
   parameter int MAX_SEGMENTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   smvg_req_if.sink    req_bus,
   smvg_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import smvg_pkg::*;

   localparam int DIV_N  = NUM_W;
   localparam int ST_A   = DIV_N;
   localparam int ST_B   = DIV_N + 1;
   localparam int ST_SIN = DIV_N + 2;
   localparam int ST_P1  = ST_SIN + SIN_N;
   localparam int ST_P2  = ST_P1 + 1;
   localparam int ST_OUT = ST_P2 + 1;
   localparam int NST    = ST_OUT + 1;
   localparam int NSIDE  = SIN_N + 2;   // side data beside sine and scaling

   // ---------------- configuration registers ----------------
   logic [CNT_W-1:0] ring_count_ff, segment_count_ff;
   logic [CNT_W-1:0] r_eff, s_eff;
   logic             csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff    <= 7'd16;
         segment_count_ff <= 7'd32;
      end else if (csr_wr) begin
         case (paddr[2])
            REG_RING: ring_count_ff    <= pwdata[CNT_W-1:0];
            REG_SEG:  segment_count_ff <= pwdata[CNT_W-1:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_RING: prdata = 32'(ring_count_ff);
         REG_SEG:  prdata = 32'(segment_count_ff);
         default:  prdata = '0;
      endcase
   end

   // zero acts as one, large counts clip to the maximum
   always_comb begin
      if (ring_count_ff == '0)                  r_eff = 7'd1;
      else if (32'(ring_count_ff) > MAX_RINGS)  r_eff = CNT_W'(MAX_RINGS);
      else                                      r_eff = ring_count_ff;
      if (segment_count_ff == '0)                    s_eff = 7'd1;
      else if (32'(segment_count_ff) > MAX_SEGMENTS) s_eff = CNT_W'(MAX_SEGMENTS);
      else                                           s_eff = segment_count_ff;
   end

   // ---------------- flow control ----------------
   // en[k]: stage k loads this cycle. A stage loads when it is empty or
   // its successor loads, so holes in the pipeline fill up.
   logic [NST:0]   en;
   logic [NST-1:0] vld_ff, vld_in, vld_prev;

   assign en[NST] = rsp_bus.ready;
   for (genvar k = 0; k < NST; k++) begin : g_en
      assign en[k] = !vld_ff[k] || en[k+1];
   end

   assign vld_prev = {vld_ff[NST-2:0], req_bus.valid};
   assign vld_in   = (en[NST-1:0] & vld_prev) | (~en[NST-1:0] & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_bus.ready = en[0];
   assign rsp_bus.valid = vld_ff[ST_OUT];

   // ---------------- divider chain ----------------
   // ring*2^23 / R and seg*2^24 / S, one quotient bit per cell
   div_type d_chain [0:DIV_N];

   always_comb begin
      d_chain[0]       = '0;
      d_chain[0].ring  = req_bus.ring_idx;
      d_chain[0].seg   = req_bus.seg_idx;
      d_chain[0].lower = req_bus.lower_copy;
      d_chain[0].num_r = {1'b0, req_bus.ring_idx, 23'b0};
      d_chain[0].num_s = {req_bus.seg_idx, 24'b0};
   end

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      smvg_div_cell u_cell (
         .clock (clock),
         .en    (en[k]),
         .r_div (r_eff),
         .s_div (s_eff),
         .din   (d_chain[k]),
         .dout  (d_chain[k+1])
      );
   end

   // ---------------- stage A: rounding, remainder rescale, products ----------
   div_type          dq;
   logic [PH_W-1:0]  a_pr_ff, a_ps_ff;
   logic [22:0]      a_vhi_ff, a_uhi_ff;
   logic [14:0]      a_vprod_ff, a_uprod_ff;
   logic [13:0]      a_rs1_ff, a_rings1_ff;
   logic [CNT_W-1:0] a_seg_ff;
   logic             a_lower_ff, a_has_ff, a_inr_ff;
   logic [CNT_W:0]   s1;
   logic             rnd_r, rnd_s;

   always_comb begin
      dq    = d_chain[DIV_N];
      s1    = {1'b0, s_eff} + 8'd1;
      // round half up: 2*rem >= divisor
      rnd_r = {dq.rem_r, 1'b0} >= {1'b0, r_eff};
      rnd_s = {dq.rem_s, 1'b0} >= {1'b0, s_eff};
   end

   always_ff @(posedge clock) begin
      if (en[ST_A]) begin
         a_pr_ff     <= dq.quo_r[PH_W-1:0] + PH_W'(rnd_r);
         a_ps_ff     <= dq.quo_s[PH_W-1:0] + PH_W'(rnd_s);
         a_vhi_ff    <= dq.quo_r[NUM_W-1:8];
         a_uhi_ff    <= dq.quo_s[NUM_W-1:8];
         // remainder of the 256x smaller dividend, times 256
         a_vprod_ff  <= 15'(dq.quo_r[7:0]) * 15'(r_eff) + 15'(dq.rem_r);
         a_uprod_ff  <= 15'(dq.quo_s[7:0]) * 15'(s_eff) + 15'(dq.rem_s);
         a_rs1_ff    <= 14'(r_eff) * 14'(s1);
         a_rings1_ff <= 14'(dq.ring) * 14'(s1);
         a_seg_ff    <= dq.seg;
         a_lower_ff  <= dq.lower;
         a_has_ff    <= dq.ring < r_eff;
         a_inr_ff    <= (dq.ring <= r_eff) && (dq.seg <= s_eff);
      end
   end

   // ---------------- stage B: texture coords, strip indices, phases --------
   logic [CNT_W-1:0] v_rem, u_rem;
   logic [23:0]      vq, uq, vsum;
   logic [IDX_W-1:0] w, off;
   side_type         side_b;
   side_type         side_b_ff;
   logic [PH_W-1:0]  ph_ff [0:NPH-1];

   always_comb begin
      v_rem    = a_vprod_ff[14:8];
      u_rem    = a_uprod_ff[14:8];
      vq       = 24'(a_vhi_ff) + 24'({v_rem, 1'b0} >= {1'b0, r_eff});
      uq       = 24'(a_uhi_ff) + 24'({u_rem, 1'b0} >= {1'b0, s_eff});
      vsum     = vq + (a_lower_ff ? 24'd32768 : 24'd0);
      side_b.v = (vsum > 24'd65536) ? 17'd65536 : vsum[TEX_W-1:0];
      side_b.u = (uq > 24'd65536) ? 17'd0 : TEX_W'(24'd65536 - uq);
      // w = (R+1)(S+1) - 1 - (ring(S+1) + seg), all modulo 2^16
      w        = 16'(a_rs1_ff) + 16'(s_eff) - 16'(a_rings1_ff) - 16'(a_seg_ff);
      off      = a_lower_ff ? 16'({a_rs1_ff, 1'b0}) : 16'd0;
      side_b.ia  = a_has_ff ? (w - 16'(s_eff) - 16'd1 + off) : 16'd0;
      side_b.ib  = a_has_ff ? (w + off) : 16'd0;
      side_b.has = a_has_ff;
      side_b.inr = a_inr_ff;
   end

   always_ff @(posedge clock) begin
      if (en[ST_B]) begin
         side_b_ff <= side_b;
         ph_ff[0]  <= a_pr_ff;
         ph_ff[1]  <= a_pr_ff + PH_QUARTER;
         ph_ff[2]  <= a_ps_ff;
         ph_ff[3]  <= a_ps_ff + PH_QUARTER;
      end
   end

   // ---------------- sine units: ring sin/cos, segment sin/cos ------------
   logic [Q30_W-1:0] s_mag [0:NPH-1];
   logic             s_neg [0:NPH-1];

   for (genvar i = 0; i < NPH; i++) begin : g_sin
      smvg_sine u_sine (
         .clock (clock),
         .en    (en[ST_SIN +: SIN_N]),
         .phase (ph_ff[i]),
         .mag   (s_mag[i]),
         .neg   (s_neg[i])
      );
   end

   // side data rides beside the sine and scaling stages
   side_type side_ff [0:NSIDE-1];

   for (genvar j = 0; j < NSIDE; j++) begin : g_side
      always_ff @(posedge clock) begin
         if (en[ST_SIN+j]) begin
            side_ff[j] <= (j == 0) ? side_b_ff : side_ff[(j == 0) ? 0 : j-1];
         end
      end
   end

   // ---------------- P1: x*r and z*r ----------------
   logic [2*Q30_W-1:0] pxr, pzr;
   logic [Q30_W-1:0]   p1_mag_ff [0:2];
   logic               p1_neg_ff [0:2];

   assign pxr = s_mag[2] * s_mag[0];
   assign pzr = s_mag[3] * s_mag[0];

   always_ff @(posedge clock) begin
      if (en[ST_P1]) begin
         p1_mag_ff[0] <= pxr[2*Q30_W-2:30];
         p1_mag_ff[1] <= s_mag[1];
         p1_mag_ff[2] <= pzr[2*Q30_W-2:30];
         p1_neg_ff[0] <= s_neg[2] ^ s_neg[0];
         p1_neg_ff[1] <= s_neg[1];
         p1_neg_ff[2] <= s_neg[3] ^ s_neg[0];
      end
   end

   // ---------------- P2: Q30 to Q6.8, rounded and clipped ----------------
   logic [MAG_W-1:0] p2_mag_ff [0:2];
   logic             p2_neg_ff [0:2];

   for (genvar c = 0; c < 3; c++) begin : g_scale
      logic [Q30_W+MAG_W:0] ps;
      assign ps = (Q30_W+MAG_W+1)'(p1_mag_ff[c]) * (Q30_W+MAG_W+1)'(POS_SCALE)
                + (Q30_W+MAG_W+1)'(32'h2000_0000);
      always_ff @(posedge clock) begin
         if (en[ST_P2]) begin
            p2_mag_ff[c] <= (ps[Q30_W+MAG_W:30] > 16'(POS_SCALE)) ? POS_SCALE
                                                                   : ps[43:30];
            p2_neg_ff[c] <= p1_neg_ff[c];
         end
      end
   end

   // ---------------- output register ----------------
   logic [POS_W-1:0] pos_in [0:2];
   logic [POS_W-1:0] pos_ff [0:2];
   side_type         out_side_ff;

   for (genvar c = 0; c < 3; c++) begin : g_sign
      assign pos_in[c] = p2_neg_ff[c] ? (POS_W'(0) - POS_W'(p2_mag_ff[c]))
                                      : POS_W'(p2_mag_ff[c]);
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         pos_ff[0]   <= pos_in[0];
         pos_ff[1]   <= pos_in[1];
         pos_ff[2]   <= pos_in[2];
         out_side_ff <= side_ff[NSIDE-1];
      end
   end

   assign rsp_bus.pos_x         = pos_ff[0];
   assign rsp_bus.pos_y         = pos_ff[1];
   assign rsp_bus.pos_z         = pos_ff[2];
   assign rsp_bus.tex_u         = out_side_ff.u;
   assign rsp_bus.tex_v         = out_side_ff.v;
   assign rsp_bus.strip_index_a = out_side_ff.ia;
   assign rsp_bus.strip_index_b = out_side_ff.ib;
   assign rsp_bus.has_indices   = out_side_ff.has;
   assign rsp_bus.in_range      = out_side_ff.inr;

`ifndef SYNTHESIS
   // an empty output slot lets the whole chain move, so a request is taken
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_bus.valid |-> req_bus.ready)
      else $error("request refused with empty output");

   // rows without a strip return zero indices
   a_no_strip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.has_indices |->
         rsp_bus.strip_index_a == '0 && rsp_bus.strip_index_b == '0)
      else $error("strip index set on last ring");

   // texture coordinates stay within one
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.tex_u <= 17'd65536 && rsp_bus.tex_v <= 17'd65536)
      else $error("texture coordinate above one");
`endif

endmodule
